// File: rtl/csl_pkg.sv
package csl_pkg;

    localparam int WORD_CHARS = 31;
    localparam int POS_BITS   = 16;
    localparam int CNT_W      = $clog2(WORD_CHARS + 1);
    localparam int ADDR_W     = $clog2(WORD_CHARS);
    localparam int KIND_W     = 6;
    localparam int KW_NUM     = 10;
    localparam int KW_MAXLEN  = 8;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_CONST    = 6'd0;
    localparam logic [KIND_W-1:0] K_ID       = 6'd1;
    localparam logic [KIND_W-1:0] K_MAIN     = 6'd2;
    localparam logic [KIND_W-1:0] K_RETURN   = 6'd3;
    localparam logic [KIND_W-1:0] K_IF       = 6'd4;
    localparam logic [KIND_W-1:0] K_ELSE     = 6'd5;
    localparam logic [KIND_W-1:0] K_FOR      = 6'd6;
    localparam logic [KIND_W-1:0] K_WHILE    = 6'd7;
    localparam logic [KIND_W-1:0] K_BREAK    = 6'd8;
    localparam logic [KIND_W-1:0] K_CONTINUE = 6'd9;
    localparam logic [KIND_W-1:0] K_TYPE     = 6'd10;
    localparam logic [KIND_W-1:0] K_LPAREN   = 6'd11;
    localparam logic [KIND_W-1:0] K_RPAREN   = 6'd12;
    localparam logic [KIND_W-1:0] K_LBRACE   = 6'd13;
    localparam logic [KIND_W-1:0] K_RBRACE   = 6'd14;
    localparam logic [KIND_W-1:0] K_SEMI     = 6'd15;
    localparam logic [KIND_W-1:0] K_COMMA    = 6'd16;
    localparam logic [KIND_W-1:0] K_ANDAND   = 6'd17;
    localparam logic [KIND_W-1:0] K_OROR     = 6'd18;
    localparam logic [KIND_W-1:0] K_EQEQ     = 6'd19;
    localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd20;
    localparam logic [KIND_W-1:0] K_NEQ      = 6'd21;
    localparam logic [KIND_W-1:0] K_NOT      = 6'd22;
    localparam logic [KIND_W-1:0] K_GE       = 6'd23;
    localparam logic [KIND_W-1:0] K_GT       = 6'd24;
    localparam logic [KIND_W-1:0] K_LE       = 6'd25;
    localparam logic [KIND_W-1:0] K_LT       = 6'd26;
    localparam logic [KIND_W-1:0] K_PLUS     = 6'd27;
    localparam logic [KIND_W-1:0] K_MINUS    = 6'd28;
    localparam logic [KIND_W-1:0] K_STAR     = 6'd29;
    localparam logic [KIND_W-1:0] K_SLASH    = 6'd30;
    localparam logic [KIND_W-1:0] K_QUEST    = 6'd31;
    localparam logic [KIND_W-1:0] K_COLON    = 6'd32;

    // Characters.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_AMP    = "&";
    localparam logic [7:0] CH_BAR    = "|";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_QUEST  = "?";
    localparam logic [7:0] CH_COLON  = ":";

    // Pending operator codes.
    localparam logic [2:0] P_NONE    = 3'd0;
    localparam logic [2:0] P_EQ      = 3'd1;
    localparam logic [2:0] P_BANG    = 3'd2;
    localparam logic [2:0] P_GT      = 3'd3;
    localparam logic [2:0] P_LT      = 3'd4;
    localparam logic [2:0] P_SLASH   = 3'd5;
    localparam logic [2:0] P_SWALLOW = 3'd6;

    // Comment modes.
    localparam logic [1:0] C_NONE  = 2'd0;
    localparam logic [1:0] C_LINE  = 2'd1;
    localparam logic [1:0] C_BLOCK = 2'd2;

    localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAXLEN] = '{
        '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0},
        '{"m", "a", "i", "n", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"f", "o", "r", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0},
        '{"b", "r", "e", "a", "k", 8'd0, 8'd0, 8'd0},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"i", "n", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"v", "o", "i", "d", 8'd0, 8'd0, 8'd0, 8'd0}
    };
    localparam logic [CNT_W-1:0] KW_LEN [KW_NUM] = '{
        CNT_W'(6), CNT_W'(4), CNT_W'(2), CNT_W'(4), CNT_W'(3),
        CNT_W'(5), CNT_W'(5), CNT_W'(8), CNT_W'(3), CNT_W'(4)
    };
    localparam logic [KIND_W-1:0] KW_KIND [KW_NUM] = '{
        K_RETURN, K_MAIN, K_IF, K_ELSE, K_FOR,
        K_WHILE, K_BREAK, K_CONTINUE, K_TYPE, K_TYPE
    };

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } csl_chr_t;

    typedef struct packed {
        logic [KIND_W-1:0]   token_kind;
        logic [POS_BITS-1:0] line_number;
        logic [POS_BITS-1:0] column_number;
        logic [7:0]          text_char;
        logic                text_valid;
        logic                word_truncated;
        logic                token_end;
        logic                last;
    } csl_tok_t;

    typedef struct packed {
        logic accept;
        logic load_pre;
        logic load_word;
        logic load_post;
        logic rd_next;
    } csl_cmd_t;

    typedef struct packed {
        logic plan_pre;
        logic plan_word;
        logic plan_post;
        logic snap_word;
        logic snap_post;
        logic word_last;
        logic out_free;
    } csl_stat_t;

    function automatic logic [KIND_W-1:0] pend_pair(input logic [2:0] p);
        logic [KIND_W-1:0] k;
        case (p)
            P_EQ:    k = K_EQEQ;
            P_BANG:  k = K_NEQ;
            P_GT:    k = K_GE;
            P_LT:    k = K_LE;
            default: k = K_CONST;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pend_single(input logic [2:0] p);
        logic [KIND_W-1:0] k;
        case (p)
            P_EQ:    k = K_ASSIGN;
            P_BANG:  k = K_NOT;
            P_GT:    k = K_GT;
            P_LT:    k = K_LT;
            P_SLASH: k = K_SLASH;
            default: k = K_CONST;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/csl_if.sv
interface csl_char_if import csl_pkg::*; ();
    logic     valid;
    logic     ready;
    csl_chr_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csl_tok_if import csl_pkg::*; ();
    logic     valid;
    logic     ready;
    csl_tok_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/csl_ram.sv
module csl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/csl_datapath.sv
module csl_datapath import csl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  csl_chr_t  in_data,
    input  csl_cmd_t  cmd,
    output csl_stat_t stat,
    output logic      out_valid,
    input  logic      out_ready,
    output csl_tok_t  out_data
);

    // Lexer state.
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] wstart_reg, wstart_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                saw_letter_reg, saw_letter_next;
    logic                saw_digit_reg, saw_digit_next;
    logic                cut_reg, cut_next;
    logic [KW_NUM-1:0]   kw_ok_reg, kw_ok_next;
    logic [2:0]          pend_reg, pend_next;
    logic [1:0]          cmode_reg, cmode_next;
    logic                star_reg, star_next;

    // Result plan captured at the accepted beat.
    logic [POS_BITS-1:0] snap_line_reg;
    logic                pre_valid_reg;
    logic [KIND_W-1:0]   pre_kind_reg;
    logic [POS_BITS-1:0] pre_col_reg;
    logic                wrd_valid_reg;
    logic [KIND_W-1:0]   wrd_kind_reg;
    logic                wrd_text_reg;
    logic                wrd_cut_reg;
    logic [POS_BITS-1:0] wrd_col_reg;
    logic [CNT_W-1:0]    wrd_n_reg;
    logic                post_valid_reg;
    logic [KIND_W-1:0]   post_kind_reg;
    logic [POS_BITS-1:0] post_col_reg;
    logic [ADDR_W-1:0]   idx_reg, idx_next;

    logic     out_valid_reg, out_valid_next;
    csl_tok_t out_reg, out_next;

    logic [7:0]          c;
    logic                nl, alnum, digit, lex;
    logic [POS_BITS-1:0] col_inc, line_inc;
    logic [KIND_W-1:0]   fl_kind;
    logic                fl_text;
    logic                plan_pre, plan_word, plan_post;
    logic [KIND_W-1:0]   pre_kind, post_kind;
    logic                wr_req;
    logic [7:0]          rdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                word_last;

    assign c       = in_data.char_in;
    assign nl      = (c == CH_NL);
    assign digit   = (c >= "0") && (c <= "9");
    assign alnum   = digit || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    assign col_inc  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;

    // Kind of the word gathered so far; keyword hits were tracked per character.
    always_comb
    begin
        fl_kind = K_ID;
        fl_text = 1'b1;
        if (saw_digit_reg && !saw_letter_reg)
        begin
            fl_kind = K_CONST;
        end
        else
        begin
            for (int k = 0; k < KW_NUM; k++)
            begin
                if (kw_ok_reg[k] && (count_reg == KW_LEN[k]))
                begin
                    fl_kind = KW_KIND[k];
                    fl_text = (KW_KIND[k] == K_MAIN);
                end
            end
        end
    end

    always_comb
    begin
        line_next       = line_reg;
        col_next        = col_reg;
        wstart_next     = wstart_reg;
        count_next      = count_reg;
        saw_letter_next = saw_letter_reg;
        saw_digit_next  = saw_digit_reg;
        cut_next        = cut_reg;
        kw_ok_next      = kw_ok_reg;
        pend_next       = pend_reg;
        cmode_next      = cmode_reg;
        star_next       = star_reg;
        plan_pre        = 1'b0;
        plan_word       = 1'b0;
        plan_post       = 1'b0;
        pre_kind        = K_CONST;
        post_kind       = K_CONST;
        lex             = 1'b0;
        wr_req          = 1'b0;

        if (in_data.end_of_text)
        begin
            plan_word = (count_reg != '0);
            if ((pend_reg >= P_EQ) && (pend_reg <= P_SLASH))
            begin
                plan_pre = 1'b1;
                pre_kind = pend_single(pend_reg);
            end
            line_next       = POS_BITS'(1);
            col_next        = '0;
            wstart_next     = '0;
            count_next      = '0;
            saw_letter_next = 1'b0;
            saw_digit_next  = 1'b0;
            cut_next        = 1'b0;
            pend_next       = P_NONE;
            cmode_next      = C_NONE;
            star_next       = 1'b0;
        end
        else
        begin
            col_next = col_inc;
            if (pend_reg == P_SWALLOW)
            begin
                pend_next = P_NONE;
                if (nl)
                begin
                    line_next = line_inc;
                    col_next  = '0;
                end
            end
            else if (cmode_reg == C_LINE)
            begin
                if (nl)
                begin
                    cmode_next = C_NONE;
                    lex        = 1'b1;
                end
            end
            else if (cmode_reg == C_BLOCK)
            begin
                if (nl)
                begin
                    line_next = line_inc;
                    col_next  = '0;
                    star_next = 1'b0;
                end
                else if (c == CH_STAR)
                begin
                    star_next = 1'b1;
                end
                else if ((c == CH_SLASH) && star_reg)
                begin
                    cmode_next = C_NONE;
                    star_next  = 1'b0;
                end
                else
                begin
                    star_next = 1'b0;
                end
            end
            else
            begin
                lex = 1'b1;
                if ((pend_reg >= P_EQ) && (pend_reg <= P_SLASH))
                begin
                    pend_next = P_NONE;
                    if ((pend_reg == P_SLASH) && (c == CH_SLASH))
                    begin
                        cmode_next = C_LINE;
                        lex        = 1'b0;
                    end
                    else if ((pend_reg == P_SLASH) && (c == CH_STAR))
                    begin
                        cmode_next = C_BLOCK;
                        star_next  = 1'b0;
                        lex        = 1'b0;
                    end
                    else if ((pend_reg != P_SLASH) && (c == CH_EQ))
                    begin
                        plan_pre = 1'b1;
                        pre_kind = pend_pair(pend_reg);
                        lex      = 1'b0;
                    end
                    else
                    begin
                        plan_pre = 1'b1;
                        pre_kind = pend_single(pend_reg);
                    end
                end
            end

            if (lex)
            begin
                if (alnum)
                begin
                    if (digit)
                    begin
                        saw_digit_next = 1'b1;
                    end
                    else
                    begin
                        saw_letter_next = 1'b1;
                    end
                    if (count_reg == '0)
                    begin
                        wstart_next = col_inc;
                    end
                    if (count_reg < CNT_W'(WORD_CHARS))
                    begin
                        wr_req     = 1'b1;
                        count_next = count_reg + 1'b1;
                        for (int k = 0; k < KW_NUM; k++)
                        begin
                            kw_ok_next[k] = ((count_reg == '0) || kw_ok_reg[k]) &&
                                            (count_reg < KW_LEN[k]) &&
                                            (c == KW_TEXT[k][count_reg[2:0]]);
                        end
                    end
                    else
                    begin
                        cut_next = 1'b1;
                    end
                end
                else
                begin
                    plan_word       = (count_reg != '0);
                    count_next      = '0;
                    saw_letter_next = 1'b0;
                    saw_digit_next  = 1'b0;
                    cut_next        = 1'b0;
                    case (c)
                        CH_LPAREN: post_kind = K_LPAREN;
                        CH_RPAREN: post_kind = K_RPAREN;
                        CH_LBRACE: post_kind = K_LBRACE;
                        CH_RBRACE: post_kind = K_RBRACE;
                        CH_SEMI:   post_kind = K_SEMI;
                        CH_COMMA:  post_kind = K_COMMA;
                        CH_AMP:
                        begin
                            post_kind = K_ANDAND;
                            pend_next = P_SWALLOW;
                        end
                        CH_BAR:
                        begin
                            post_kind = K_OROR;
                            pend_next = P_SWALLOW;
                        end
                        CH_EQ:     pend_next = P_EQ;
                        CH_BANG:   pend_next = P_BANG;
                        CH_GT:     pend_next = P_GT;
                        CH_LT:     pend_next = P_LT;
                        CH_SLASH:  pend_next = P_SLASH;
                        CH_PLUS:   post_kind = K_PLUS;
                        CH_MINUS:  post_kind = K_MINUS;
                        CH_STAR:   post_kind = K_STAR;
                        CH_QUEST:  post_kind = K_QUEST;
                        CH_COLON:  post_kind = K_COLON;
                        CH_NL:
                        begin
                            line_next = line_inc;
                            col_next  = '0;
                        end
                        default:   post_kind = K_CONST;
                    endcase
                    plan_post = (post_kind != K_CONST);
                end
            end
        end
    end

    csl_ram #(
        .WIDTH (8),
        .DEPTH (WORD_CHARS)
    ) u_word_ram (
        .clk   (clk),
        .we    (cmd.accept && wr_req),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (c),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // The first character is fetched on the accepted beat, the rest one ahead of each load.
    assign ram_re    = cmd.accept || cmd.rd_next;
    assign ram_raddr = cmd.rd_next ? ADDR_W'(idx_reg + 1'b1) : '0;
    assign word_last = ((CNT_W'(idx_reg) + 1'b1) == wrd_n_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            idx_next = ADDR_W'(idx_reg + 1'b1);
        end
    end

    always_comb
    begin
        out_next             = out_reg;
        out_next.line_number = snap_line_reg;
        if (cmd.load_pre)
        begin
            out_next.token_kind     = pre_kind_reg;
            out_next.column_number  = pre_col_reg;
            out_next.text_char      = '0;
            out_next.text_valid     = 1'b0;
            out_next.word_truncated = 1'b0;
            out_next.token_end      = 1'b1;
            out_next.last           = !wrd_valid_reg && !post_valid_reg;
        end
        else if (cmd.load_word)
        begin
            out_next.token_kind     = wrd_kind_reg;
            out_next.column_number  = wrd_col_reg;
            out_next.text_char      = wrd_text_reg ? rdata : 8'd0;
            out_next.text_valid     = wrd_text_reg;
            out_next.word_truncated = wrd_cut_reg;
            out_next.token_end      = word_last;
            out_next.last           = word_last && !post_valid_reg;
        end
        else
        begin
            out_next.token_kind     = post_kind_reg;
            out_next.column_number  = post_col_reg;
            out_next.text_char      = '0;
            out_next.text_valid     = 1'b0;
            out_next.word_truncated = 1'b0;
            out_next.token_end      = 1'b1;
            out_next.last           = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_pre || cmd.load_word || cmd.load_post)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg       <= POS_BITS'(1);
            col_reg        <= '0;
            wstart_reg     <= '0;
            count_reg      <= '0;
            saw_letter_reg <= 1'b0;
            saw_digit_reg  <= 1'b0;
            cut_reg        <= 1'b0;
            kw_ok_reg      <= '0;
            pend_reg       <= P_NONE;
            cmode_reg      <= C_NONE;
            star_reg       <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                line_reg       <= line_next;
                col_reg        <= col_next;
                wstart_reg     <= wstart_next;
                count_reg      <= count_next;
                saw_letter_reg <= saw_letter_next;
                saw_digit_reg  <= saw_digit_next;
                cut_reg        <= cut_next;
                kw_ok_reg      <= kw_ok_next;
                pend_reg       <= pend_next;
                cmode_reg      <= cmode_next;
                star_reg       <= star_next;
            end
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            snap_line_reg  <= line_reg;
            pre_valid_reg  <= plan_pre;
            pre_kind_reg   <= pre_kind;
            pre_col_reg    <= col_reg;
            wrd_valid_reg  <= plan_word;
            wrd_kind_reg   <= fl_kind;
            wrd_text_reg   <= fl_text;
            wrd_cut_reg    <= cut_reg;
            wrd_col_reg    <= wstart_reg;
            wrd_n_reg      <= fl_text ? count_reg : CNT_W'(1);
            post_valid_reg <= plan_post;
            post_kind_reg  <= post_kind;
            post_col_reg   <= col_inc;
        end
        if (cmd.load_pre || cmd.load_word || cmd.load_post)
        begin
            out_reg <= out_next;
        end
    end

    assign stat.plan_pre  = plan_pre;
    assign stat.plan_word = plan_word;
    assign stat.plan_post = plan_post;
    assign stat.snap_word = wrd_valid_reg && !pre_valid_reg ? 1'b1 : wrd_valid_reg;
    assign stat.snap_post = post_valid_reg;
    assign stat.word_last = word_last;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/csl_ctrl.sv
module csl_ctrl import csl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  csl_stat_t stat,
    output csl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PRE  = 2'd1;
    localparam logic [1:0] S_WRD  = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (stat.plan_pre)
                    begin
                        state_next = S_PRE;
                    end
                    else if (stat.plan_word)
                    begin
                        state_next = S_WRD;
                    end
                    else if (stat.plan_post)
                    begin
                        state_next = S_POST;
                    end
                end
            end
            S_PRE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_pre = 1'b1;
                    if (stat.snap_word)
                    begin
                        state_next = S_WRD;
                    end
                    else if (stat.snap_post)
                    begin
                        state_next = S_POST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_word = 1'b1;
                    cmd.rd_next   = !stat.word_last;
                    if (stat.word_last)
                    begin
                        state_next = stat.snap_post ? S_POST : S_IDLE;
                    end
                end
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.load_post = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load_pre, cmd.load_word, cmd.load_post}))
        else $error("more than one controller command in a cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_pre || cmd.load_word || cmd.load_post) |-> stat.out_free)
        else $error("result loaded while the output register is busy");

    a_post_planned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST) |-> stat.snap_post)
        else $error("operator token phase without a planned operator token");

    a_quiet_char: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !(stat.plan_pre || stat.plan_word || stat.plan_post))
        |=> (state_reg == S_IDLE))
        else $error("character with no result left the idle state");

endmodule

// File: rtl/c_subset_lexer.sv
// Order: a character with results moves the controller from idle to its PRE, WRD or POST state,
// where the first result is loaded into the output register once that register is free; each
// further result is loaded as the sink frees the register. Characters are taken only in the idle
// state, so the next one waits for this one's last result; the word buffer RAM gives one char per load.
// Reset (rst_n, asynchronous, active low) puts the lexer at line 1, column 0, with no word,
// operator or comment pending; the word buffer is not cleared and needs no clearing pass.
module c_subset_lexer import csl_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    csl_char_if.sink  chars,
    csl_tok_if.source tokens
);

    csl_cmd_t  cmd;
    csl_stat_t stat;

    csl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (chars.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (tokens.valid),
        .out_ready (tokens.ready),
        .out_data  (tokens.data)
    );

endmodule
